// File: sv/prefix_sum_tree_assert.svh
// Assertion macros used by prefix_sum_tree.sv.
`ifndef PREFIX_SUM_TREE_ASSERT_SVH
`define PREFIX_SUM_TREE_ASSERT_SVH

// Checked only while out of reset.
`define PST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pst_pkg.sv
`timescale 1ns / 1ps

package pst_pkg;

  localparam int SIZE   = 1024;
  localparam int ADDR_W = $clog2(SIZE);
  localparam int DATA_W = 32;
  localparam int POS_W  = 10;
  localparam int DELTA_W = 16;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SIZE - 1);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

// File: sv/pst_store.sv
`timescale 1ns / 1ps

module pst_store
  import pst_pkg::*;
(
  input  logic              clk,
  input  store_req_t        req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [SIZE];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/prefix_sum_tree.sv
`timescale 1ns / 1ps
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------
// input    | in_kind, in_position, in_delta          | taken when start && !busy
// result   | out_prefix_sum                          | out_valid, one cycle only
//
// An update or query holds busy while it visits at most 10 tree entries, one
// read per cycle through the single read port, with the add and write-back
// in the cycle after each read; a final step then posts the result. A clear
// holds busy while it writes zero to all SIZE entries.
// After reset the block sweeps the store to zero with busy high.
// The result shows for exactly one cycle, the first with busy low; no stall.

module prefix_sum_tree
  import pst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_kind,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [DELTA_W-1:0] in_delta,
  output logic                      out_valid,
  output logic signed [DATA_W-1:0]  out_prefix_sum
);

  `include "prefix_sum_tree_assert.svh"

  state_t              state_r, state_nxt;
  logic [ADDR_W:0]     idx_r, idx_nxt;
  logic                is_query_r, is_query_nxt;
  logic [DELTA_W-1:0]  delta_r, delta_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_sum_r, out_sum_nxt;

  store_req_t          req;
  logic [DATA_W-1:0]   rd_data;
  logic [ADDR_W:0]     low_bit;
  logic                walk_go;
  logic [DATA_W-1:0]   add_a;
  logic [DATA_W-1:0]   sum;

  pst_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign low_bit = idx_r & (~idx_r + 1'b1);
  assign walk_go = (idx_r != '0) && !idx_r[ADDR_W];

  // Shared adder: accumulate on query, read-modify-write on update.
  assign add_a = is_query_r ? acc_r : {{(DATA_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
  assign sum   = add_a + rd_data;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    is_query_nxt  = is_query_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    pend_vld_nxt  = 1'b0;
    pend_addr_nxt = pend_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    req           = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (kind_t'(in_kind))
            KIND_ADD: begin
              idx_nxt      = (ADDR_W+1)'(in_position);
              is_query_nxt = 1'b0;
              delta_nxt    = in_delta;
              state_nxt    = ST_WALK;
            end
            KIND_QUERY: begin
              idx_nxt      = (ADDR_W+1)'(in_position);
              is_query_nxt = 1'b1;
              acc_nxt      = '0;
              state_nxt    = ST_WALK;
            end
            KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              // drop unused kind
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          req.re        = 1'b1;
          req.raddr     = idx_r[ADDR_W-1:0];
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = idx_r[ADDR_W-1:0];
          idx_nxt       = is_query_r ? (idx_r - low_bit) : (idx_r + low_bit);
        end
        if (pend_vld_r) begin
          if (is_query_r) begin
            acc_nxt = sum;
          end else begin
            req.we    = 1'b1;
            req.waddr = pend_addr_r;
            req.wdata = sum;
          end
        end
        if (!walk_go && !pend_vld_r) begin
          out_valid_nxt = is_query_r;
          out_sum_nxt   = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        req.we      = 1'b1;
        req.waddr   = clr_cnt_r;
        req.wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    is_query_r  <= is_query_nxt;
    delta_r     <= delta_nxt;
    acc_r       <= acc_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_prefix_sum = out_sum_r;

  `PST_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe held two cycles")
  `PST_ASSERT(a_no_rw_clash, (req.we && req.re) |-> (req.waddr != req.raddr), "read-write clash")
  `PST_ASSERT(a_idle_drained, !busy |-> !pend_vld_r, "idle with a read still pending")
  `PST_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (state_r == ST_CLEAR), "reset did not start clearing")

endmodule

// File: tb/sv/prefix_sum_tree_tb.sv
`timescale 1ns / 1ps

module prefix_sum_tree_tb;
  import pst_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_RANDOM = 400;

  // Tracks the tree contents and the prefix sums still owed by the block.
  class prefix_sum_ledger;
    bit [DATA_W-1:0] node_sums[SIZE];
    bit [DATA_W-1:0] owed_sums[$];
    int mismatches;

    function void note_item(logic [1:0] kind, logic [POS_W-1:0] pos,
                            logic signed [DELTA_W-1:0] delta);
      bit [ADDR_W:0]   idx;
      bit [DATA_W-1:0] amount;
      bit [DATA_W-1:0] acc;
      amount = {{(DATA_W-DELTA_W){delta[DELTA_W-1]}}, delta};
      idx = (ADDR_W+1)'(pos);
      acc = '0;
      case (kind)
        KIND_ADD: begin
          // walk upward; position zero adds nothing
          if (idx != 0) begin
            while (idx < SIZE) begin
              node_sums[idx] += amount;
              idx += idx & (~idx + 1'b1);
            end
          end
        end
        KIND_QUERY: begin
          if (idx >= SIZE) idx = (ADDR_W+1)'(SIZE - 1);
          while (idx != 0) begin
            acc += node_sums[idx];
            idx -= idx & (~idx + 1'b1);
          end
          owed_sums.push_back(acc);
        end
        KIND_CLEAR: begin
          foreach (node_sums[i]) node_sums[i] = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_sum(logic signed [DATA_W-1:0] got);
      logic signed [DATA_W-1:0] want;
      if (owed_sums.size() == 0) begin
        $display("%0t: prefix sum %0d with no query pending", $time, got);
        mismatches++;
      end else begin
        want = owed_sums.pop_front();
        if (got !== want) begin
          $display("%0t: prefix sum mismatch, expected %0d, got %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_kind;
  logic [POS_W-1:0]          in_position;
  logic signed [DELTA_W-1:0] in_delta;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_prefix_sum;

  prefix_sum_ledger ledger;
  bit quiet;

  prefix_sum_tree uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_delta      (in_delta),
    .out_valid     (out_valid),
    .out_prefix_sum(out_prefix_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Check results before noting a new item taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_sum(out_prefix_sum);
      if (start && !busy) ledger.note_item(in_kind, in_position, in_delta);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic [1:0] kind, logic [POS_W-1:0] pos,
                           logic signed [DELTA_W-1:0] delta);
    if (!quiet && $urandom_range(99) < 31) begin
      start       = 1'b0;
      in_kind     = 2'($urandom);
      in_position = POS_W'($urandom);
      in_delta    = DELTA_W'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start       = 1'b1;
    in_kind     = kind;
    in_position = pos;
    in_delta    = delta;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int r;
    logic [1:0]                kind;
    logic [POS_W-1:0]          pos;
    logic signed [DELTA_W-1:0] delta;
    ledger      = new();
    quiet       = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_ADD;
    in_position = '0;
    in_delta    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty tree, ignored updates, extremes of position and delta
    send_item(KIND_QUERY, 10'd0, 16'sd0);
    send_item(KIND_QUERY, 10'd1023, 16'sd0);
    send_item(KIND_ADD, 10'd0, 16'sd5);
    send_item(KIND_QUERY, 10'd1023, 16'sd0);
    send_item(KIND_ADD, 10'd1, 16'sd32767);
    send_item(KIND_ADD, 10'd1023, -16'sd32768);
    send_item(KIND_ADD, 10'd512, -16'sd1);
    send_item(KIND_ADD, 10'd2, 16'sd1);
    send_item(KIND_QUERY, 10'd1, 16'sd0);
    send_item(KIND_QUERY, 10'd2, 16'sd0);
    send_item(KIND_QUERY, 10'd511, 16'sd0);
    send_item(KIND_QUERY, 10'd512, 16'sd0);
    send_item(KIND_QUERY, 10'd1022, 16'sd0);
    send_item(KIND_QUERY, 10'd1023, -16'sd1);
    send_item(KIND_UNUSED, 10'd7, 16'sd100);
    send_item(KIND_QUERY, 10'd0, -16'sd32768);
    send_item(KIND_CLEAR, 10'd1023, -16'sd1);
    send_item(KIND_QUERY, 10'd1023, 16'sd0);
    send_item(KIND_ADD, 10'd768, 16'sd12345);
    send_item(KIND_QUERY, 10'd767, 16'sd0);
    send_item(KIND_QUERY, 10'd768, 16'sd0);

    // check the totals back to back, then empty the store
    quiet = 1'b1;
    send_item(KIND_QUERY, 10'd1023, 16'sd0);
    send_item(KIND_QUERY, 10'd1022, 16'sd0);
    send_item(KIND_CLEAR, 10'd0, 16'sd0);
    quiet = 1'b0;

    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= 150 && i < 250);
      r = $urandom_range(99);
      if (r < 50) kind = KIND_ADD;
      else if (r < 90) kind = KIND_QUERY;
      else if (r < 95) kind = KIND_CLEAR;
      else kind = KIND_UNUSED;
      case ($urandom_range(9))
        0: pos = '0;
        1: pos = '1;
        2: pos = 10'd1 << $urandom_range(9);
        3, 4: pos = POS_W'($urandom_range(1, 16));
        default: pos = POS_W'($urandom);
      endcase
      case ($urandom_range(7))
        0: delta = 16'sh7fff;
        1: delta = 16'sh8000;
        2: delta = DELTA_W'($urandom_range(0, 15) - 8);
        default: delta = DELTA_W'($urandom);
      endcase
      send_item(kind, pos, delta);
    end
    start = 1'b0;

    while (ledger.owed_sums.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.owed_sums.size() != 0)
      $display("%0t: %0d prefix sums never arrived", $time, ledger.owed_sums.size());
    if (ledger.mismatches == 0 && ledger.owed_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pst_pkg.sv
sv/pst_store.sv
sv/prefix_sum_tree.sv
tb/sv/prefix_sum_tree_tb.sv
